>>> sv/wgb_pkg.sv
package wgb_pkg;

    localparam int unsigned BURST_BYTES  = 32;
    localparam int unsigned BEAT_BYTES   = 8;
    localparam int unsigned BEATS        = BURST_BYTES / BEAT_BYTES;
    localparam int unsigned GATHER_BYTES = BURST_BYTES + BEAT_BYTES;
    localparam int unsigned HELD_W       = $clog2(GATHER_BYTES + 1);
    localparam int unsigned BEAT_W       = $clog2(BEATS);
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned DATA_W       = 8 * BEAT_BYTES;
    localparam int unsigned BURST_W      = 8 * BURST_BYTES;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned REG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0] ADDR_MASK    = 32'h0000_001f;
    localparam logic [31:0]       RETIRE_RESET = 32'd65536;

    typedef enum logic {
        MODE_STORE = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    typedef enum logic {
        KIND_BEAT = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GATHER_ADDRESS = 1'b0,
        REG_RETIRE_TICKS   = 1'b1
    } t_reg_idx;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   burst_address;
        logic [BURST_W-1:0]  burst_data;
        logic                not_empty;
    } t_result;

endpackage

>>> sv/wgb_if.sv
interface wgb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [wgb_pkg::COUNT_W-1:0]  byte_count;
    logic [wgb_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output mode, output byte_count, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input byte_count, input write_data,
                    output ready);
endinterface

interface wgb_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [wgb_pkg::ADDR_W-1:0]   burst_address;
    logic [wgb_pkg::DATA_W-1:0]   beat_data;
    logic                         last_beat;
    logic                         not_empty;

    modport source (output valid, output kind, output burst_address, output beat_data,
                    output last_beat, output not_empty, input ready);
    modport sink   (input valid, input kind, input burst_address, input beat_data,
                    input last_beat, input not_empty, output ready);
endinterface

interface wgb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wgb_pkg::REG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/wgb_gather.sv
module wgb_gather (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wgb_in_if.sink                     i_in,
    input  logic [wgb_pkg::ADDR_W-1:0] i_gather_address,
    input  logic [31:0]                i_retire_ticks,
    input  logic                       i_slot_free,
    output logic                       o_load,
    output wgb_pkg::t_result           o_result
);

    logic                        r_in_valid;
    logic                        r_mode;
    logic [wgb_pkg::COUNT_W-1:0] r_byte_count;
    logic [wgb_pkg::DATA_W-1:0]  r_write_data;

    wgb_pkg::t_byte              r_bytes [wgb_pkg::GATHER_BYTES];
    logic [wgb_pkg::HELD_W-1:0]  r_held;
    logic [31:0]                 r_retire_count;

    wgb_pkg::t_byte              w_merged [wgb_pkg::GATHER_BYTES];
    logic [3:0]                  w_eff;
    logic [wgb_pkg::HELD_W-1:0]  w_total;
    logic                        w_is_tick;
    logic                        w_burst;
    logic                        w_produces;
    logic                        w_advance;
    logic [31:0]                 w_count_inc;
    logic                        w_retire;
    logic [wgb_pkg::BURST_W-1:0] w_burst_data;

    always_comb begin
        logic [wgb_pkg::HELD_W-1:0] off;
        logic [2:0]                 sel;
        off = '0;
        sel = '0;
        w_eff = r_byte_count[3] ? 4'd8 : r_byte_count;
        w_total = r_held + wgb_pkg::HELD_W'(w_eff);
        for (int i = 0; i < wgb_pkg::GATHER_BYTES; i++) begin
            off = wgb_pkg::HELD_W'(i) - r_held;
            if (wgb_pkg::HELD_W'(i) >= r_held && off < wgb_pkg::HELD_W'(w_eff)) begin
                sel = 3'(w_eff - 4'd1 - off[3:0]);
                w_merged[i] = r_write_data[8*sel +: 8];
            end else begin
                w_merged[i] = r_bytes[i];
            end
        end
        for (int i = 0; i < wgb_pkg::BURST_BYTES; i++) begin
            w_burst_data[wgb_pkg::BURST_W-1-8*i -: 8] = w_merged[i];
        end
    end

    assign w_is_tick   = (r_mode == wgb_pkg::MODE_TICK);
    assign w_burst     = (w_total >= wgb_pkg::HELD_W'(wgb_pkg::BURST_BYTES));
    assign w_produces  = w_is_tick || w_burst;
    assign w_advance   = r_in_valid && (!w_produces || i_slot_free);
    assign w_count_inc = r_retire_count + 32'd1;
    assign w_retire    = (w_count_inc >= i_retire_ticks);

    assign i_in.ready = !r_in_valid || w_advance;
    assign o_load     = r_in_valid && w_produces && i_slot_free;

    always_comb begin
        o_result = '0;
        if (w_is_tick) begin
            o_result.kind      = wgb_pkg::KIND_TICK;
            o_result.not_empty = !w_retire && (r_held != '0);
        end else begin
            o_result.kind          = wgb_pkg::KIND_BEAT;
            o_result.burst_address = i_gather_address & ~wgb_pkg::ADDR_MASK;
            o_result.burst_data    = w_burst_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode       <= i_in.mode;
            r_byte_count <= i_in.byte_count;
            r_write_data <= i_in.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= '0;
            r_retire_count <= '0;
        end else if (w_advance) begin
            if (w_is_tick) begin
                r_retire_count <= w_retire ? 32'd0 : w_count_inc;
                r_held         <= w_retire ? '0 : r_held;
            end else begin
                r_held <= w_burst ? w_total - wgb_pkg::HELD_W'(wgb_pkg::BURST_BYTES) : w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !w_is_tick) begin
            for (int i = 0; i < wgb_pkg::GATHER_BYTES; i++) begin
                if (w_burst && i < wgb_pkg::GATHER_BYTES - wgb_pkg::BURST_BYTES) begin
                    r_bytes[i] <= w_merged[i + wgb_pkg::BURST_BYTES];
                end else begin
                    r_bytes[i] <= w_merged[i];
                end
            end
        end
    end

endmodule

>>> sv/wgb_burst_out.sv
module wgb_burst_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wgb_pkg::t_result i_result,
    output logic             o_slot_free,
    wgb_out_if.source        o_out
);

    logic                        r_valid;
    logic [wgb_pkg::BEAT_W-1:0]  r_beat;
    wgb_pkg::t_result            r_res;

    logic                        w_last;
    logic                        w_take;
    logic                        w_is_tick;

    assign w_is_tick   = (r_res.kind == wgb_pkg::KIND_TICK);
    assign w_last      = w_is_tick || (r_beat == wgb_pkg::BEAT_W'(wgb_pkg::BEATS - 1));
    assign w_take      = r_valid && o_out.ready;
    assign o_slot_free = !r_valid || (w_take && w_last);

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_res.kind;
    assign o_out.burst_address = r_res.burst_address;
    assign o_out.beat_data     = w_is_tick ? '0
                               : r_res.burst_data[wgb_pkg::BURST_W-1-wgb_pkg::DATA_W*r_beat -:
                                                  wgb_pkg::DATA_W];
    assign o_out.last_beat     = !w_is_tick && w_last;
    assign o_out.not_empty     = r_res.not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end
            r_beat <= r_beat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

endmodule

>>> sv/write_gather_burst_buffer_unit.sv
// Write gather buffer for CPU stores. Items arrive on i_in: a store carries up to 8
// bytes in the low bytes of write_data, entered most significant byte first, and a tick
// advances the retire counter. Results leave on o_out. Whenever 32 or more bytes are held
// after a store, a burst of four 64-bit beats goes out, earliest byte in the top bits,
// tagged with the gather address aligned to 32 bytes; last_beat marks the fourth beat.
// A tick returns one status beat whose not_empty tells whether data is still held; when
// the retire count reaches its limit the held bytes are dropped first.
// Registers are written on i_cfg, index 0 gather address and index 1 retire limit; the
// user must write them only while the block is idle; the block does not enforce this.
// That port is always ready. An item is accepted in every cycle while the result
// register is free for any result that it makes. A burst holds the result register for
// four beats, so an item that makes a result waits in the input register until the last
// beat is taken, while a store that makes no result passes through. When the receiver
// stalls, the input register fills and i_in.ready drops. Synchronous reset empties the
// buffer, clears the retire counter, sets the gather address to zero and the retire
// limit to 65536.
module write_gather_burst_buffer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wgb_in_if.sink    i_in,
    wgb_cfg_if.sink   i_cfg,
    wgb_out_if.source o_out
);

    logic [wgb_pkg::ADDR_W-1:0] r_gather_address;
    logic [31:0]                r_retire_ticks;

    logic                       w_load;
    logic                       w_slot_free;
    wgb_pkg::t_result           w_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather_address <= '0;
            r_retire_ticks   <= wgb_pkg::RETIRE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                wgb_pkg::REG_GATHER_ADDRESS: r_gather_address <= i_cfg.data;
                wgb_pkg::REG_RETIRE_TICKS:   r_retire_ticks   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    wgb_gather u_gather (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .i_gather_address (r_gather_address),
        .i_retire_ticks   (r_retire_ticks),
        .i_slot_free      (w_slot_free),
        .o_load           (w_load),
        .o_result         (w_result)
    );

    wgb_burst_out u_burst_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_result    (w_result),
        .o_slot_free (w_slot_free),
        .o_out       (o_out)
    );

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_BYTES   = 128;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        wgb_pkg::t_kind             kind;
        logic [wgb_pkg::ADDR_W-1:0] burst_address;
        logic [wgb_pkg::DATA_W-1:0] beat_data;
        logic                       last_beat;
        logic                       not_empty;
    } t_beat;

    class burst_scoreboard;
        wgb_pkg::t_byte ring [RING_BYTES];
        logic [6:0]     rd_pos;
        logic [6:0]     wr_pos;
        logic [31:0]    retire_cnt;
        logic [31:0]    gather_addr;
        logic [31:0]    retire_limit;
        t_beat          expected [$];
        int             errors;
        int             stores;
        int             ticks;
        int             bursts;
        int             statuses;

        function new();
            empty_ring();
            gather_addr  = '0;
            retire_limit = wgb_pkg::RETIRE_RESET;
        endfunction

        function void empty_ring();
            foreach (ring[i]) ring[i] = '0;
            rd_pos     = '0;
            wr_pos     = '0;
            retire_cnt = '0;
        endfunction

        function void write_reg(wgb_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                wgb_pkg::REG_GATHER_ADDRESS: gather_addr  = value;
                wgb_pkg::REG_RETIRE_TICKS:   retire_limit = value;
                default: ;
            endcase
        endfunction

        function void note_input(wgb_pkg::t_mode mode, logic [wgb_pkg::COUNT_W-1:0] cnt,
                                 logic [wgb_pkg::DATA_W-1:0] data);
            t_beat       b;
            int          n;
            int          i;
            int          k;
            logic [6:0]  held;
            logic [63:0] word;
            b = '0;
            if (mode == wgb_pkg::MODE_TICK) begin
                ticks++;
                retire_cnt++;
                if (retire_cnt >= retire_limit) empty_ring();
                b.kind      = wgb_pkg::KIND_TICK;
                b.not_empty = (rd_pos != wr_pos);
                expected.push_back(b);
                return;
            end
            stores++;
            n = (cnt > 8) ? 8 : int'(cnt);
            for (i = n - 1; i >= 0; i--) begin
                ring[wr_pos] = data[8*i +: 8];
                wr_pos++;
            end
            held = wr_pos - rd_pos;
            if (held < wgb_pkg::BURST_BYTES) return;
            bursts++;
            for (k = 0; k < wgb_pkg::BEATS; k++) begin
                word = '0;
                for (i = 0; i < wgb_pkg::BEAT_BYTES; i++) begin
                    word = {word[55:0], ring[rd_pos]};
                    rd_pos++;
                end
                b.kind          = wgb_pkg::KIND_BEAT;
                b.burst_address = gather_addr & ~wgb_pkg::ADDR_MASK;
                b.beat_data     = word;
                b.last_beat     = (k == wgb_pkg::BEATS - 1);
                b.not_empty     = 1'b0;
                expected.push_back(b);
            end
        endfunction

        task report(string what);
            if (errors < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(t_beat got);
            t_beat want;
            if (expected.size() == 0) begin
                report($sformatf("result with none pending, kind %0d data %h",
                                 got.kind, got.beat_data));
                return;
            end
            want = expected.pop_front();
            if (want.kind == wgb_pkg::KIND_TICK) statuses++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.burst_address !== want.burst_address)
                report($sformatf("burst_address %h, want %h",
                                 got.burst_address, want.burst_address));
            if (got.beat_data !== want.beat_data)
                report($sformatf("beat_data %h, want %h", got.beat_data, want.beat_data));
            if (got.last_beat !== want.last_beat)
                report($sformatf("last_beat %0d, want %0d", got.last_beat, want.last_beat));
            if (got.not_empty !== want.not_empty)
                report($sformatf("not_empty %0d, want %0d", got.not_empty, want.not_empty));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles = 0;

    burst_scoreboard sb = new();

    wgb_in_if  in_if ();
    wgb_out_if out_if ();
    wgb_cfg_if cfg_if ();

    write_gather_burst_buffer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind          = wgb_pkg::t_kind'(out_if.kind);
            got.burst_address = out_if.burst_address;
            got.beat_data     = out_if.beat_data;
            got.last_beat     = out_if.last_beat;
            got.not_empty     = out_if.not_empty;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a beat.", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(wgb_pkg::t_mode mode, logic [wgb_pkg::COUNT_W-1:0] cnt,
                             logic [wgb_pkg::DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= mode;
        in_if.byte_count <= cnt;
        in_if.write_data <= data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(mode, cnt, data);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int          r;
        logic [3:0]  cnt;
        logic [63:0] data;
        r    = $urandom_range(99);
        data = {$urandom(), $urandom()};
        if (r < 10) begin
            send_item(wgb_pkg::MODE_TICK, 4'($urandom_range(15)), data);
        end else if (r < 85) begin
            cnt = 4'(1 << $urandom_range(3));
            send_item(wgb_pkg::MODE_STORE, cnt, data);
        end else begin
            send_item(wgb_pkg::MODE_STORE, 4'($urandom_range(15)), data);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(wgb_pkg::t_reg_idx idx, logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, logic [31:0] addr, logic [31:0] limit);
        drain();
        write_reg(wgb_pkg::REG_GATHER_ADDRESS, addr);
        write_reg(wgb_pkg::REG_RETIRE_TICKS, limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random();
            if (i == PHASE_ITEMS / 2) drain();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        in_if.valid       = 1'b0;
        in_if.mode        = wgb_pkg::MODE_STORE;
        in_if.byte_count  = '0;
        in_if.write_data  = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = wgb_pkg::REG_GATHER_ADDRESS;
        cfg_if.data       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset register values: address zero and the large retire limit.
        repeat (4) send_item(wgb_pkg::MODE_STORE, 4'd8, {$urandom(), $urandom()});
        send_item(wgb_pkg::MODE_TICK, 4'd8, '0);
        drain();

        write_reg(wgb_pkg::REG_GATHER_ADDRESS, 32'hffff_ffff);
        write_reg(wgb_pkg::REG_RETIRE_TICKS, 32'd3);
        send_item(wgb_pkg::MODE_TICK, 4'd2, 64'h0123_4567_89ab_cdef);
        send_item(wgb_pkg::MODE_STORE, 4'd8, 64'hffff_ffff_ffff_ffff);
        send_item(wgb_pkg::MODE_STORE, 4'd1, 64'hffff_ffff_ffff_ff5a);
        send_item(wgb_pkg::MODE_STORE, 4'd2, 64'h0123_4567_89ab_cdef);
        send_item(wgb_pkg::MODE_STORE, 4'd4, 64'h0123_4567_89ab_cdef);
        send_item(wgb_pkg::MODE_STORE, 4'd3, 64'hfedc_ba98_7654_3210);
        send_item(wgb_pkg::MODE_STORE, 4'd5, 64'hfedc_ba98_7654_3210);
        send_item(wgb_pkg::MODE_STORE, 4'd6, 64'h0000_0000_0000_0000);
        send_item(wgb_pkg::MODE_STORE, 4'd7, 64'h8000_0000_0000_0001);
        send_item(wgb_pkg::MODE_STORE, 4'd0, 64'hffff_ffff_ffff_ffff);
        send_item(wgb_pkg::MODE_STORE, 4'd9, 64'h1122_3344_5566_7788);
        send_item(wgb_pkg::MODE_STORE, 4'd15, 64'h99aa_bbcc_ddee_ff00);
        send_item(wgb_pkg::MODE_TICK, 4'd0, 64'hffff_ffff_ffff_ffff);
        send_item(wgb_pkg::MODE_STORE, 4'd2, 64'h0000_0000_0000_a55a);
        send_item(wgb_pkg::MODE_TICK, 4'd15, 64'hffff_ffff_ffff_ffff);

        run_phase(23, 60, {$urandom()}, 32'd5);
        run_phase(60, 23, 32'h0000_0000, 32'hffff_ffff);
        run_phase(0, 0, {$urandom()} | 32'h1f, 32'd0);
        drain();

        $display("Sent %0d stores and %0d ticks; checked %0d bursts and %0d tick statuses",
                 sb.stores, sb.ticks, sb.bursts, sb.statuses);
        $display("under five register settings, including zero and maximum retire limits.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches.", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
